>>> rtl/rgbhsv_pkg.sv
// Shared constants, types and helpers for the RGB to HSV converter.
package rgbhsv_pkg;

  localparam int unsigned CompBits  = 8;
  localparam int unsigned HueBits   = 13;
  localparam int unsigned QuoBits   = 10;   // 960*diff/delta fits below 1024
  localparam int unsigned DivSteps  = QuoBits;
  localparam int unsigned NumCells  = DivSteps;
  localparam int unsigned NumBits   = 18;   // numerators up to 960*255 or 255*255
  localparam int unsigned RemBits   = CompBits + 1;

  localparam logic [HueBits-1:0] HueSector    = 13'd960;
  localparam logic [HueBits-1:0] HueGreenBase = 13'd1920;
  localparam logic [HueBits-1:0] HueBlueBase  = 13'd3840;
  localparam logic [HueBits-1:0] HueFullTurn  = 13'd5760;

  localparam int unsigned InBytes  = (3 * CompBits + 7) / 8;
  localparam int unsigned OutBytes = (HueBits + 2 * CompBits + 7) / 8;

  // Payload that rides along one restoring-division cell.
  typedef struct packed {
    logic                 valid;
    logic [NumBits-1:0]   hue_num;   // shifted numerator of the hue quotient
    logic [RemBits-1:0]   hue_rem;
    logic [QuoBits-1:0]   hue_quo;
    logic [CompBits-1:0]  hue_den;
    logic [NumBits-1:0]   sat_num;
    logic [RemBits-1:0]   sat_rem;
    logic [QuoBits-1:0]   sat_quo;
    logic [CompBits-1:0]  sat_den;
    logic                 neg;
    logic [HueBits-1:0]   base;
    logic                 gray;
    logic [CompBits-1:0]  vmax;
  } cell_t;

endpackage

>>> rtl/rgbhsv_cell.sv
// One restoring-division cell: retires one quotient bit of both divisions.
module rgbhsv_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  rgbhsv_pkg::cell_t cell_i,
  output rgbhsv_pkg::cell_t cell_o
);

  rgbhsv_pkg::cell_t cell_d, cell_q;
  logic [rgbhsv_pkg::RemBits:0] hue_try, sat_try;

  // Shift in the next numerator bit and subtract the divisor where it fits
  always_comb begin
    cell_d  = cell_i;
    hue_try = {cell_i.hue_rem, cell_i.hue_num[rgbhsv_pkg::NumBits-1]}
              - {2'b00, cell_i.hue_den};
    sat_try = {cell_i.sat_rem, cell_i.sat_num[rgbhsv_pkg::NumBits-1]}
              - {2'b00, cell_i.sat_den};
    cell_d.hue_num = {cell_i.hue_num[rgbhsv_pkg::NumBits-2:0], 1'b0};
    cell_d.sat_num = {cell_i.sat_num[rgbhsv_pkg::NumBits-2:0], 1'b0};
    if (!hue_try[rgbhsv_pkg::RemBits]) begin
      cell_d.hue_rem = hue_try[rgbhsv_pkg::RemBits-1:0];
    end else begin
      cell_d.hue_rem = {cell_i.hue_rem[rgbhsv_pkg::RemBits-2:0],
                        cell_i.hue_num[rgbhsv_pkg::NumBits-1]};
    end
    if (!sat_try[rgbhsv_pkg::RemBits]) begin
      cell_d.sat_rem = sat_try[rgbhsv_pkg::RemBits-1:0];
    end else begin
      cell_d.sat_rem = {cell_i.sat_rem[rgbhsv_pkg::RemBits-2:0],
                        cell_i.sat_num[rgbhsv_pkg::NumBits-1]};
    end
    cell_d.hue_quo = {cell_i.hue_quo[rgbhsv_pkg::QuoBits-2:0], ~hue_try[rgbhsv_pkg::RemBits]};
    cell_d.sat_quo = {cell_i.sat_quo[rgbhsv_pkg::QuoBits-2:0], ~sat_try[rgbhsv_pkg::RemBits]};
  end

  // Advance the cell, clear it under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

>>> rtl/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter: front stage, cell chain, output stage.
//
//  channel | direction | tdata fields (lowest bit first)
//  s_axis  | in        | red[7:0], green[15:8], blue[23:16]
//  m_axis  | out       | hue[12:0], saturation[20:13], brightness[28:21]
//
// One pixel per cycle sustained while m_axis is not stalled; the path is one front register, one
// cell per quotient bit (10 cells, each a 10-bit subtract), one output register.
// Reset clears the valid bits of every stage. A stall on m_axis freezes the
// whole chain; s_axis_tready is low only while the full output stage is held.
module rgb_to_hsv_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red, green, blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // hue, saturation, brightness, zero pad
);

  localparam int unsigned CB = rgbhsv_pkg::CompBits;

  logic [CB-1:0] red, green, blue, vmax, vmin, delta;
  logic [CB-1:0] dp, dq;
  logic          en;
  logic [rgbhsv_pkg::NumBits-1:0] hue_prod, sat_prod;
  rgbhsv_pkg::cell_t front_d, front_q;
  rgbhsv_pkg::cell_t chain [rgbhsv_pkg::NumCells+1];
  logic [rgbhsv_pkg::HueBits-1:0] hue_d, hue_q;
  logic [CB-1:0] sat_q, val_q;
  logic          out_valid_q;
  rgbhsv_pkg::cell_t last;

  // Advance the whole chain unless the output holds an untaken result
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  assign red   = s_axis_tdata[CB-1:0];
  assign green = s_axis_tdata[2*CB-1:CB];
  assign blue  = s_axis_tdata[3*CB-1:2*CB];

  // Find max, min, sector and the signed difference; form the products and
  // align them with the first quotient bit
  always_comb begin
    vmax = red;
    if (green > vmax) vmax = green;
    if (blue > vmax) vmax = blue;
    vmin = red;
    if (green < vmin) vmin = green;
    if (blue < vmin) vmin = blue;
    delta = vmax - vmin;
    front_d = '0;
    priority if (red == vmax) begin
      dp = green; dq = blue; front_d.base = '0;
    end else if (green == vmax) begin
      dp = blue; dq = red; front_d.base = rgbhsv_pkg::HueGreenBase;
    end else begin
      dp = red; dq = green; front_d.base = rgbhsv_pkg::HueBlueBase;
    end
    hue_prod = ((dp >= dq) ? rgbhsv_pkg::NumBits'(dp - dq)
                           : rgbhsv_pkg::NumBits'(dq - dp))
               * rgbhsv_pkg::NumBits'(rgbhsv_pkg::HueSector);
    sat_prod = rgbhsv_pkg::NumBits'(delta) * rgbhsv_pkg::NumBits'((1 << CB) - 1);
    front_d.valid   = s_axis_tvalid;
    front_d.neg     = dp < dq;
    front_d.gray    = (delta == '0);
    front_d.vmax    = vmax;
    front_d.hue_den = delta;
    front_d.sat_den = vmax;
    front_d.hue_rem = rgbhsv_pkg::RemBits'(hue_prod >> rgbhsv_pkg::QuoBits);
    front_d.sat_rem = rgbhsv_pkg::RemBits'(sat_prod >> rgbhsv_pkg::QuoBits);
    front_d.hue_num = {hue_prod[rgbhsv_pkg::QuoBits-1:0],
                       {(rgbhsv_pkg::NumBits-rgbhsv_pkg::QuoBits){1'b0}}};
    front_d.sat_num = {sat_prod[rgbhsv_pkg::QuoBits-1:0],
                       {(rgbhsv_pkg::NumBits-rgbhsv_pkg::QuoBits){1'b0}}};
  end

  // Register the front stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
    end else if (en) begin
      front_q <= front_d;
    end
  end

  assign chain[0] = front_q;

  // Chain of division cells, one quotient bit each
  for (genvar i = 0; i < rgbhsv_pkg::NumCells; i++) begin : g_cell
    rgbhsv_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  assign last = chain[rgbhsv_pkg::NumCells];

  // Place the quotient around the sector base and wrap negatives; gray pixels get hue zero
  always_comb begin
    logic [rgbhsv_pkg::HueBits-1:0] mag;
    mag = rgbhsv_pkg::HueBits'(last.hue_quo);
    if (last.gray) begin
      hue_d = '0;
    end else if (!last.neg) begin
      hue_d = last.base + mag;
    end else if (mag > last.base) begin
      hue_d = last.base + rgbhsv_pkg::HueFullTurn - mag;
    end else begin
      hue_d = last.base - mag;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_q <= hue_d;
      sat_q <= (last.vmax == '0) ? '0 : CB'(last.sat_quo);
      val_q <= last.vmax;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, val_q, sat_q, hue_q};

  // A result that waits while stalled keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Hue never leaves its turn
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> hue_q < rgbhsv_pkg::HueFullTurn)
    else $error("hue out of range");

  // Gray results carry no hue or saturation
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && last.valid && last.gray |=> hue_q == '0 && sat_q == '0)
    else $error("gray pixel got hue or saturation");

  // Input is refused only while the output is stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> out_valid_q && !m_axis_tready)
    else $error("input refused without stall");

endmodule
